### rtl/sgps_pkg.sv
// Shared types, constants and defaults for the softened gravity particle step block.
package sgps_pkg;

  localparam int MAX_BODIES_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int TERM_W = 59;
  localparam logic [TERM_W-1:0] TERM_CAP = TERM_W'(1) << 58;

  localparam logic [1:0] CFG_TIME_STEP     = 2'd0;
  localparam logic [1:0] CFG_GRAVITY_CONST = 2'd1;
  localparam logic [1:0] CFG_SOFTEN_SQ     = 2'd2;
  localparam logic [1:0] CFG_BODY_COUNT    = 2'd3;

  typedef enum logic [1:0] {
    OP_BODY = 2'd0,
    OP_GRAV = 2'd1,
    OP_MOVE = 2'd2
  } op_t;

  typedef struct packed {
    logic               req_type;
    logic [3:0]         body_index;
    logic [30:0]        body_mass_in;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] life_left;
    logic               gravity_on;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_life;
    logic               is_dead;
  } out_item_t;

  typedef struct packed {
    op_t                op;
    logic [3:0]         body_index;
    logic [30:0]        body_mass;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] life;
  } work_t;

  typedef struct packed {
    logic  vld;
    work_t item;
  } work_port_t;

endpackage

### rtl/sgps_front.sv
// Input side: accepts, classifies and queues items; drops out-of-range bodies.
module sgps_front import sgps_pkg::*; #(
  parameter int MAX_BODIES = MAX_BODIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  in_item_t   in_data,
  output logic       in_full,
  input  logic       deq,
  output work_port_t wq
);

  work_t      slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  work_t      item_c;
  logic       keep_c, acc_c, push_c, pop_c;

  always_comb begin
    item_c.body_index = in_data.body_index;
    item_c.body_mass  = in_data.body_mass_in;
    item_c.pos_x      = in_data.pos_x;
    item_c.pos_y      = in_data.pos_y;
    item_c.vel_x      = in_data.vel_x;
    item_c.vel_y      = in_data.vel_y;
    item_c.life       = in_data.life_left;
    keep_c            = 1'b1;
    if (!in_data.req_type) begin
      item_c.op = OP_BODY;
      keep_c    = 32'(in_data.body_index) < MAX_BODIES;
    end else if (in_data.gravity_on) begin
      item_c.op = OP_GRAV;
    end else begin
      item_c.op = OP_MOVE;
    end
  end

  assign in_full = cnt_r == 2'd2;
  assign acc_c   = in_push && !in_full;
  assign push_c  = acc_c && keep_c;
  assign pop_c   = deq && (cnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_c) begin
        slot_r[wr_ptr_r] <= item_c;
        wr_ptr_r         <= !wr_ptr_r;
      end
      if (pop_c) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push_c) - 2'(pop_c);
    end
  end

  assign wq.vld  = cnt_r != 2'd0;
  assign wq.item = slot_r[rd_ptr_r];

endmodule

### rtl/sgps_isqrt.sv
// Bit-serial floor square root of a 62-bit value giving a 31-bit root; a start while busy restarts it.
module sgps_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [61:0] x,
  output logic        done,
  output logic [30:0] root
);

  logic [61:0] rem_r;
  logic [62:0] res_r, bit_r, t_c;
  logic        run_r, done_r, ge_c;

  assign t_c  = res_r + bit_r;
  assign ge_c = {1'b0, rem_r} >= t_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        rem_r <= x;
        res_r <= '0;
        bit_r <= 63'(1) << 62;
      end else if (run_r) begin
        if (ge_c) begin
          rem_r <= rem_r - t_c[61:0];
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[30:0];

endmodule

### rtl/sgps_div.sv
// Restoring divider, one quotient bit per cycle, quotient capped at the term limit.
module sgps_div import sgps_pkg::*; #(
  parameter int NUMW = 95,
  parameter int DENW = 84
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUMW-1:0]   num,
  input  logic [DENW-1:0]   den,
  output logic              done,
  output logic [TERM_W-1:0] quo
);

  localparam int HW  = NUMW - TERM_W;
  localparam int TW  = (HW > DENW) ? HW : DENW;
  localparam int CNW = $clog2(TERM_W);

  logic [DENW:0]     rem_r, trial_c, rem_c;
  logic [DENW-1:0]   den_r;
  logic [TERM_W-1:0] sh_r, q_r;
  logic [CNW-1:0]    cnt_r;
  logic              run_r, done_r, ovf_r, ge_c;

  always_comb begin
    trial_c = {rem_r[DENW-1:0], sh_r[TERM_W-1]};
    ge_c    = trial_c >= {1'b0, den_r};
    rem_c   = ge_c ? trial_c - {1'b0, den_r} : trial_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNW'(TERM_W - 1);
        rem_r <= (DENW+1)'(num[NUMW-1:TERM_W]);
        sh_r  <= num[TERM_W-1:0];
        den_r <= den;
        ovf_r <= TW'(num[NUMW-1:TERM_W]) >= TW'(den);
        q_r   <= '0;
      end else if (run_r) begin
        rem_r <= rem_c;
        q_r   <= {q_r[TERM_W-2:0], ge_c};
        sh_r  <= sh_r << 1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = (ovf_r || q_r > TERM_CAP) ? TERM_CAP : q_r;

endmodule

### rtl/sgps_back.sv
// Back end: body table, per-body gravity sequencer and Euler update with result register.
module sgps_back import sgps_pkg::*; #(
  parameter int MAX_BODIES = MAX_BODIES_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  work_port_t  wq,
  output logic        deq,
  input  logic [15:0] time_step,
  input  logic [30:0] gravity_const,
  input  logic [30:0] soften_sq,
  input  logic [4:0]  body_count,
  input  logic        out_pop,
  output logic        out_empty,
  output out_item_t   out_data
);

  localparam int BW    = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int CW    = $clog2(MAX_BODIES + 1);
  localparam int R2W   = 66 - FRAC_BITS;
  localparam int SQW   = 65 - FRAC_BITS;
  localparam int ROOTW = 34;
  localparam int DENW  = R2W + ROOTW;
  localparam int GMW   = 62;
  localparam int NUMW  = 95;
  localparam int SUMW  = TERM_W + CW + 1;
  localparam int SHW   = $clog2(FRAC_BITS / 2 + 1);

  typedef enum logic [16:0] {
    S_IDLE = 17'b00000000000000001,
    S_RD   = 17'b00000000000000010,
    S_DIFF = 17'b00000000000000100,
    S_SQ   = 17'b00000000000001000,
    S_R2   = 17'b00000000000010000,
    S_E    = 17'b00000000000100000,
    S_SQRT = 17'b00000000001000000,
    S_MUL0 = 17'b00000000010000000,
    S_MUL1 = 17'b00000000100000000,
    S_SUM  = 17'b00000001000000000,
    S_DIV  = 17'b00000010000000000,
    S_ACC  = 17'b00000100000000000,
    S_ADT  = 17'b00001000000000000,
    S_AMUL = 17'b00010000000000000,
    S_VUP  = 17'b00100000000000000,
    S_PMUL = 17'b01000000000000000,
    S_PUP  = 17'b10000000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [31:0] mem_x [MAX_BODIES];
  logic signed [31:0] mem_y [MAX_BODIES];
  logic [30:0]        mem_m [MAX_BODIES];
  logic signed [31:0] rdx_r, rdy_r;
  logic [30:0]        rdm_r;

  logic signed [31:0] px_r, py_r, vx_r, vy_r, life_r, ax_r, ay_r;
  logic [CW-1:0]      i_r, n_r, n_c;
  logic               last_c;
  logic [32:0]        mx_r, my_r;
  logic               nx_r, ny_r;
  logic [GMW-1:0]     gm_r;
  logic [SQW-1:0]     sqx_r, sqy_r;
  logic [R2W-1:0]     r2_r;
  logic [SHW-1:0]     sh_r, sh_c;
  logic [ROOTW-1:0]   root_r;
  logic [R2W+16:0]    den_lo_r, den_hi_r;
  logic [GMW+16:0]    nxl_r, nyl_r;
  logic [GMW+15:0]    nxh_r, nyh_r;
  logic [DENW-1:0]    den_r;
  logic [NUMW-1:0]    numx_r, numy_r;
  logic               div_go_r;
  logic signed [SUMW-1:0] accx_r, accy_r, tx_c, ty_c;
  logic [48:0]        prdx_r, prdy_r;
  logic               out_vld_r;
  out_item_t          out_r;

  logic signed [32:0] dx_c, dy_c;
  logic [65:0]        psx_c, psy_c;
  logic [61:0]        sq_x_c;
  logic               sq_go_c, sq_done;
  logic [30:0]        sq_root;
  logic               dvx_done, dvy_done;
  logic [TERM_W-1:0]  qx, qy;
  logic [31:0]        dtq_c;
  int                 e_c;

  function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
    if (&v[34:31] || ~|v[34:31]) return v[31:0];
    return v[34] ? 32'sh80000000 : 32'sh7fffffff;
  endfunction

  function automatic logic signed [31:0] sat_sum(input logic signed [SUMW-1:0] v);
    if (&v[SUMW-1:31] || ~|v[SUMW-1:31]) return v[31:0];
    return v[SUMW-1] ? 32'sh80000000 : 32'sh7fffffff;
  endfunction

  function automatic logic [32:0] mag33(input logic signed [31:0] v);
    logic signed [32:0] w;
    w = {v[31], v};
    return v[31] ? unsigned'(-w) : unsigned'(w);
  endfunction

  function automatic logic signed [34:0] dt_term(input logic [48:0] p, input logic neg);
    logic signed [34:0] m;
    m = $signed({2'b00, p[48:16]});
    return neg ? -m : m;
  endfunction

  sgps_isqrt u_isqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sq_go_c),
    .x    (sq_x_c),
    .done (sq_done),
    .root (sq_root)
  );

  sgps_div #(.NUMW(NUMW), .DENW(DENW)) u_div_x (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_go_r),
    .num  (numx_r),
    .den  (den_r),
    .done (dvx_done),
    .quo  (qx)
  );

  sgps_div #(.NUMW(NUMW), .DENW(DENW)) u_div_y (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_go_r),
    .num  (numy_r),
    .den  (den_r),
    .done (dvy_done),
    .quo  (qy)
  );

  always_comb begin
    n_c    = (32'(body_count) > MAX_BODIES) ? CW'(MAX_BODIES) : CW'(body_count);
    last_c = CW'(i_r + 1'b1) == n_r;
    dx_c   = $signed({rdx_r[31], rdx_r}) - $signed({px_r[31], px_r});
    dy_c   = $signed({rdy_r[31], rdy_r}) - $signed({py_r[31], py_r});
    psx_c  = 66'(mx_r) * 66'(mx_r);
    psy_c  = 66'(my_r) * 66'(my_r);
    tx_c   = $signed({{(SUMW-TERM_W){1'b0}}, qx});
    ty_c   = $signed({{(SUMW-TERM_W){1'b0}}, qy});
    dtq_c  = (FRAC_BITS >= 16) ? (32'(time_step) << ((FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0))
                               : (32'(time_step) >> ((FRAC_BITS < 16) ? 16 - FRAC_BITS : 0));
  end

  // range reduction so the radicand fits the root unit
  always_comb begin
    e_c = FRAC_BITS;
    for (int k = 0; k < FRAC_BITS / 2 + 1; k++) begin
      if (e_c > 1 && (r2_r >> (62 - e_c)) != '0) e_c = e_c - 2;
    end
    sq_x_c  = 62'(r2_r) << e_c;
    sh_c    = SHW'((FRAC_BITS - e_c) >> 1);
    sq_go_c = (state_r == S_E) && (r2_r != '0);
  end

  assign deq = (state_r == S_IDLE) && wq.vld;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (wq.vld) begin
          case (wq.item.op)
            OP_GRAV: state_nxt = (n_c == '0) ? S_ADT : S_RD;
            OP_MOVE: state_nxt = S_ADT;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD:   state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_SQ;
      S_SQ:   state_nxt = S_R2;
      S_R2:   state_nxt = S_E;
      S_E: begin
        if (r2_r != '0) state_nxt = S_SQRT;
        else state_nxt = last_c ? S_ADT : S_RD;
      end
      S_SQRT: if (sq_done) state_nxt = S_MUL0;
      S_MUL0: state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_SUM;
      S_SUM:  state_nxt = S_DIV;
      S_DIV:  if (dvx_done && dvy_done) state_nxt = S_ACC;
      S_ACC:  state_nxt = last_c ? S_ADT : S_RD;
      S_ADT:  state_nxt = S_AMUL;
      S_AMUL: state_nxt = S_VUP;
      S_VUP:  state_nxt = S_PMUL;
      S_PMUL: state_nxt = S_PUP;
      S_PUP:  if (!out_vld_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
      div_go_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      div_go_r <= state_r == S_SUM;
      if (state_r == S_PUP && !out_vld_r) out_vld_r <= 1'b1;
      else if (out_pop) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deq && wq.item.op == OP_BODY) begin
      mem_x[BW'(wq.item.body_index)] <= wq.item.pos_x;
      mem_y[BW'(wq.item.body_index)] <= wq.item.pos_y;
      mem_m[BW'(wq.item.body_index)] <= wq.item.body_mass;
    end
    rdx_r <= mem_x[i_r[BW-1:0]];
    rdy_r <= mem_y[i_r[BW-1:0]];
    rdm_r <= mem_m[i_r[BW-1:0]];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        px_r   <= wq.item.pos_x;
        py_r   <= wq.item.pos_y;
        vx_r   <= wq.item.vel_x;
        vy_r   <= wq.item.vel_y;
        life_r <= wq.item.life;
        n_r    <= n_c;
        i_r    <= '0;
        accx_r <= '0;
        accy_r <= '0;
      end
      S_DIFF: begin
        mx_r <= dx_c[32] ? unsigned'(-dx_c) : unsigned'(dx_c);
        my_r <= dy_c[32] ? unsigned'(-dy_c) : unsigned'(dy_c);
        nx_r <= dx_c[32];
        ny_r <= dy_c[32];
        gm_r <= GMW'(gravity_const) * GMW'(rdm_r);
      end
      S_SQ: begin
        sqx_r <= SQW'(psx_c >> FRAC_BITS);
        sqy_r <= SQW'(psy_c >> FRAC_BITS);
      end
      S_R2: r2_r <= R2W'(sqx_r) + R2W'(sqy_r) + R2W'(soften_sq);
      S_E: begin
        sh_r <= sh_c;
        if (r2_r == '0) i_r <= CW'(i_r + 1'b1);
      end
      S_SQRT: if (sq_done) root_r <= ROOTW'(sq_root) << sh_r;
      S_MUL0: begin
        den_lo_r <= (R2W+17)'(r2_r) * (R2W+17)'(root_r[16:0]);
        nxl_r    <= (GMW+17)'(gm_r) * (GMW+17)'(mx_r[16:0]);
        nyl_r    <= (GMW+17)'(gm_r) * (GMW+17)'(my_r[16:0]);
      end
      S_MUL1: begin
        den_hi_r <= (R2W+17)'(r2_r) * (R2W+17)'(root_r[ROOTW-1:17]);
        nxh_r    <= (GMW+16)'(gm_r) * (GMW+16)'(mx_r[32:17]);
        nyh_r    <= (GMW+16)'(gm_r) * (GMW+16)'(my_r[32:17]);
      end
      S_SUM: begin
        den_r  <= DENW'(den_lo_r) + (DENW'(den_hi_r) << 17);
        numx_r <= NUMW'(nxl_r) + (NUMW'(nxh_r) << 17);
        numy_r <= NUMW'(nyl_r) + (NUMW'(nyh_r) << 17);
      end
      S_ACC: begin
        accx_r <= nx_r ? accx_r - tx_c : accx_r + tx_c;
        accy_r <= ny_r ? accy_r - ty_c : accy_r + ty_c;
        i_r    <= CW'(i_r + 1'b1);
      end
      S_ADT: begin
        ax_r <= sat_sum(accx_r);
        ay_r <= sat_sum(accy_r);
      end
      S_AMUL: begin
        prdx_r <= 49'(mag33(ax_r)) * 49'(time_step);
        prdy_r <= 49'(mag33(ay_r)) * 49'(time_step);
      end
      S_VUP: begin
        vx_r <= sat35($signed({{3{vx_r[31]}}, vx_r}) + dt_term(prdx_r, ax_r[31]));
        vy_r <= sat35($signed({{3{vy_r[31]}}, vy_r}) + dt_term(prdy_r, ay_r[31]));
      end
      S_PMUL: begin
        prdx_r <= 49'(mag33(vx_r)) * 49'(time_step);
        prdy_r <= 49'(mag33(vy_r)) * 49'(time_step);
        px_r   <= sat35($signed({{3{px_r[31]}}, px_r}));
        life_r <= sat35($signed({{3{life_r[31]}}, life_r}) - $signed({3'b000, dtq_c}));
      end
      S_PUP: begin
        if (!out_vld_r) begin
          out_r.new_pos_x <= sat35($signed({{3{px_r[31]}}, px_r}) + dt_term(prdx_r, vx_r[31]));
          out_r.new_pos_y <= sat35($signed({{3{py_r[31]}}, py_r}) + dt_term(prdy_r, vy_r[31]));
          out_r.new_vel_x <= vx_r;
          out_r.new_vel_y <= vy_r;
          out_r.new_life  <= life_r;
          out_r.is_dead   <= life_r[31] || (life_r == '0);
        end
      end
      default: ;
    endcase
  end

  assign out_empty = !out_vld_r;
  assign out_data  = out_r;

endmodule

### rtl/softened_gravity_particle_step_top.sv
// Top level: configuration registers, front queue and gravity back end.
// A body write passes through the front queue and is written to the body table when the back end
// takes it; a particle leaves the front queue once the back end is idle. Each active body runs the
// serial square root and divider; a body at zero distance with no softening skips both and adds
// nothing. One item at a time in the back end.
// Reset (synchronous, rst_n low) empties the front queue and the result register and loads the register defaults;
// the body table keeps its contents and is undefined until written.
module softened_gravity_particle_step_top import sgps_pkg::*; #(
  parameter int MAX_BODIES = MAX_BODIES_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  in_item_t    in_data,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [15:0] time_step_r;
  logic [30:0] gravity_const_r, soften_sq_r;
  logic [4:0]  body_count_r;
  work_port_t  wq;
  logic        deq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r     <= 16'd1092;
      gravity_const_r <= 31'd65536;
      soften_sq_r     <= 31'd65536;
      body_count_r    <= 5'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TIME_STEP:     time_step_r     <= cfg_data[15:0];
        CFG_GRAVITY_CONST: gravity_const_r <= cfg_data[30:0];
        CFG_SOFTEN_SQ:     soften_sq_r     <= cfg_data[30:0];
        CFG_BODY_COUNT:    body_count_r    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  sgps_front #(.MAX_BODIES(MAX_BODIES)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_push(in_push),
    .in_data(in_data),
    .in_full(in_full),
    .deq    (deq),
    .wq     (wq)
  );

  sgps_back #(.MAX_BODIES(MAX_BODIES), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .wq           (wq),
    .deq          (deq),
    .time_step    (time_step_r),
    .gravity_const(gravity_const_r),
    .soften_sq    (soften_sq_r),
    .body_count   (body_count_r),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_data     (out_data)
  );

endmodule

### sim/softened_gravity_particle_step_top_tb.sv
// Testbench for the softened gravity particle step block: random and directed items, self-checking.
module softened_gravity_particle_step_top_tb import sgps_pkg::*;;

  localparam int LIMIT = 3000000;
  localparam logic [63:0] CAP = 64'd1 << 58;

  logic clk, rst_n;
  logic in_push, in_full, out_empty, out_pop;
  in_item_t in_data;
  out_item_t out_data;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  softened_gravity_particle_step_top i_dut (.*);

  // predictor state
  longint signed tbl_x [16];
  longint signed tbl_y [16];
  logic [63:0] tbl_m [16];
  logic [15:0] ts;
  logic [63:0] g_const, soften;
  logic [4:0] n_bodies;

  in_item_t particle_q[$];
  out_item_t step_q[$];
  int errors, n_done, cyc, gap, stall, hold;
  bit quiet, held;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic logic signed [31:0] sat32(longint signed v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] res = 0;
    logic [63:0] b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint signed times_dt(longint signed v);
    logic [63:0] m = (((v < 0) ? -v : v) * {48'd0, ts}) >> 16;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic void pull(input longint signed px, py, output longint signed ax, ay);
    int n;
    int e;
    longint signed sx, sy, dx, dy;
    logic [63:0] mx, my, r2, root, gm;
    logic [127:0] den, tx, ty;
    n = (n_bodies > 16) ? 16 : n_bodies;
    sx = 0;
    sy = 0;
    for (int i = 0; i < n; i++) begin
      dx = tbl_x[i] - px;
      dy = tbl_y[i] - py;
      mx = (dx < 0) ? -dx : dx;
      my = (dy < 0) ? -dy : dy;
      r2 = ((mx * mx) >> 16) + ((my * my) >> 16) + soften;
      if (r2 == 0) continue;
      e = 16;
      while (e > 1 && (r2 >> (62 - e)) != 0) e -= 2;
      root = isqrt(r2 << e) << ((16 - e) / 2);
      den = {64'd0, r2} * {64'd0, root};
      gm = g_const * tbl_m[i];
      tx = ({64'd0, gm} * {64'd0, mx}) / den;
      ty = ({64'd0, gm} * {64'd0, my}) / den;
      if (tx > CAP) tx = CAP;
      if (ty > CAP) ty = CAP;
      sx += (dx < 0) ? -longint'(tx[63:0]) : longint'(tx[63:0]);
      sy += (dy < 0) ? -longint'(ty[63:0]) : longint'(ty[63:0]);
    end
    ax = sat32(sx);
    ay = sat32(sy);
  endfunction

  function automatic void predict_step(in_item_t it);
    longint signed px, py, vx, vy, ax, ay, lf;
    out_item_t r;
    px = it.pos_x;
    py = it.pos_y;
    vx = it.vel_x;
    vy = it.vel_y;
    if (!it.req_type) begin
      tbl_x[it.body_index] = px;
      tbl_y[it.body_index] = py;
      tbl_m[it.body_index] = {33'd0, it.body_mass_in};
      return;
    end
    if (it.gravity_on) begin
      pull(px, py, ax, ay);
      vx = sat32(vx + times_dt(ax));
      vy = sat32(vy + times_dt(ay));
    end
    px = sat32(px + times_dt(vx));
    py = sat32(py + times_dt(vy));
    lf = sat32(longint'(it.life_left) - longint'({48'd0, ts}));
    r.new_pos_x = px[31:0];
    r.new_pos_y = py[31:0];
    r.new_vel_x = vx[31:0];
    r.new_vel_y = vy[31:0];
    r.new_life = lf[31:0];
    r.is_dead = (lf <= 0);
    step_q.push_back(r);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 0;
      in_data <= '0;
      gap <= 0;
    end else begin
      if (in_push && !in_full) predict_step(in_data);
      if (!in_push || !in_full) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_push <= 0;
        end else if (particle_q.size() > 0) begin
          in_data <= particle_q.pop_front();
          in_push <= 1;
          if (!quiet && $urandom_range(0, 3) == 0) gap <= $urandom_range(1, 3);
        end else begin
          in_push <= 0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 0;
      stall <= 0;
      hold <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (step_q.size() == 0) begin
          $display("mismatch: result with none expected");
          errors++;
        end else begin
          out_item_t w;
          w = step_q.pop_front();
          if (out_data.new_pos_x !== w.new_pos_x) report("new_pos_x", out_data.new_pos_x, w.new_pos_x);
          if (out_data.new_pos_y !== w.new_pos_y) report("new_pos_y", out_data.new_pos_y, w.new_pos_y);
          if (out_data.new_vel_x !== w.new_vel_x) report("new_vel_x", out_data.new_vel_x, w.new_vel_x);
          if (out_data.new_vel_y !== w.new_vel_y) report("new_vel_y", out_data.new_vel_y, w.new_vel_y);
          if (out_data.new_life !== w.new_life) report("new_life", out_data.new_life, w.new_life);
          if (out_data.is_dead !== w.is_dead) report("is_dead", out_data.is_dead, w.is_dead);
        end
        n_done++;
      end
      if (!held && n_done == 60) begin
        held <= 1;
        hold <= 600;
        out_pop <= 0;
      end else if (hold > 0) begin
        hold <= hold - 1;
        out_pop <= 0;
      end else if (stall > 0) begin
        stall <= stall - 1;
        out_pop <= 0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall <= $urandom_range(0, 2);
        out_pop <= 0;
      end else begin
        out_pop <= 1;
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      CFG_TIME_STEP: ts = val[15:0];
      CFG_GRAVITY_CONST: g_const = {33'd0, val[30:0]};
      CFG_SOFTEN_SQ: soften = {33'd0, val[30:0]};
      CFG_BODY_COUNT: n_bodies = val[4:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (particle_q.size() == 0 && !in_push && step_q.size() == 0);
    repeat (400) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return $urandom_range(0, 1) ? 32'h0 : 32'hffffffff;
      3, 4: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rnd_item(bit body);
    in_item_t it;
    it.req_type = !body;
    it.body_index = 4'($urandom_range(0, 15));
    it.body_mass_in = $urandom_range(0, 3) == 0 ? 31'h7fffffff : 31'($urandom);
    it.pos_x = rnd32();
    it.pos_y = rnd32();
    it.vel_x = rnd32();
    it.vel_y = rnd32();
    it.life_left = rnd32();
    it.gravity_on = $urandom_range(0, 3) != 0;
    return it;
  endfunction

  initial begin
    in_item_t it;
    logic [31:0] v;
    int n;
    rst_n = 0;
    cfg_valid = 0;
    cfg_index = CFG_TIME_STEP;
    cfg_data = 0;
    errors = 0;
    n_done = 0;
    cyc = 0;
    quiet = 0;
    held = 0;
    ts = 16'd1092;
    g_const = 65536;
    soften = 65536;
    n_bodies = 0;
    for (int i = 0; i < 16; i++) begin
      tbl_x[i] = 0;
      tbl_y[i] = 0;
      tbl_m[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1;

    // fill the whole body table, extremes first
    for (int i = 0; i < 16; i++) begin
      it = rnd_item(1);
      it.body_index = 4'(i);
      if (i == 0) begin
        it.pos_x = 32'h80000000;
        it.pos_y = 32'h7fffffff;
        it.body_mass_in = 31'h7fffffff;
      end else if (i == 1) begin
        it.pos_x = 0;
        it.pos_y = 0;
        it.body_mass_in = 0;
      end
      particle_q.push_back(it);
    end
    it = rnd_item(0);
    it.life_left = 32'sd1092;
    it.gravity_on = 1;
    particle_q.push_back(it);
    it.life_left = 32'h80000000;
    it.gravity_on = 0;
    it.pos_x = 32'h7fffffff;
    it.vel_x = 32'h7fffffff;
    it.pos_y = 32'h80000000;
    it.vel_y = 32'h80000000;
    particle_q.push_back(it);
    it.life_left = 32'h7fffffff;
    particle_q.push_back(it);
    drain();

    write_reg(CFG_BODY_COUNT, 32'd16);
    write_reg(CFG_GRAVITY_CONST, 32'h7fffffff);
    write_reg(CFG_SOFTEN_SQ, 32'd0);
    write_reg(CFG_TIME_STEP, 32'd65535);
    // particle sitting on a body with no softening
    it = rnd_item(0);
    it.gravity_on = 1;
    it.pos_x = 0;
    it.pos_y = 0;
    particle_q.push_back(it);
    it.pos_x = 32'h7fffffff;
    it.pos_y = 32'h80000000;
    particle_q.push_back(it);
    it = rnd_item(0);
    it.gravity_on = 1;
    particle_q.push_back(it);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      v = $urandom_range(0, 3);
      write_reg(CFG_TIME_STEP, v == 0 ? 32'd0 : v == 1 ? 32'd65535 : $urandom);
      v = $urandom_range(0, 3);
      write_reg(CFG_GRAVITY_CONST, v == 0 ? 32'd0 : v == 1 ? 32'h7fffffff : $urandom);
      v = $urandom_range(0, 3);
      write_reg(CFG_SOFTEN_SQ, v == 0 ? 32'd0 : v == 1 ? 32'h7fffffff : $urandom);
      if (ph == 0) v = 0;
      else if (ph == 3) v = 16;
      else if (ph == 5) v = $urandom_range(17, 31);
      else v = $urandom_range(1, 3);
      write_reg(CFG_BODY_COUNT, v);
      n = (v >= 16) ? 15 : 200;
      if (ph == 8) quiet = 1;
      for (int k = 0; k < n; k++) particle_q.push_back(rnd_item($urandom_range(0, 3) == 0));
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
